FILE: design/vngs_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and the cosine weight table of the value noise grid sampler
package vngs_pkg;

    localparam int CFG_W     = 7;
    localparam int CFG_AW    = 2;
    localparam int COORD_W   = 15;
    localparam int VALUE_W   = 16;
    localparam int S_TDATA_W = 48;
    localparam int PROD_W    = 33;

    localparam logic [16:0] W_ONE = 17'h10000;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_WRITE  = 1'b1;

    typedef enum logic [CFG_AW-1:0] {
        CFG_GRID_WIDTH  = 2'd0,
        CFG_GRID_HEIGHT = 2'd1,
        CFG_INTERP_MODE = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic cmd_wr;
        logic wr_ok;
        logic oob;
    } t_ctl;

    typedef logic [VALUE_W-1:0] t_cos_lut [256];

    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam longint unsigned TAYLOR_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                     64'd110, 64'd156, 64'd210};

    // round(65536 * sin^2(pi*t/512)) with Q30 taylor arithmetic
    function automatic t_cos_lut build_cos_lut();
        t_cos_lut        lut;
        longint unsigned x;
        longint unsigned term;
        longint unsigned sq;
        longint          sum;
        for (int t = 0; t < 256; t++) begin
            x    = (PI_Q30 * 64'(t) + 64'd256) >> 9;
            term = x;
            sum  = longint'(x);
            for (int k = 1; k <= 7; k++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / TAYLOR_DIV[k];
                if (k[0]) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            if (sum > (longint'(1) << 30)) begin
                sum = longint'(1) << 30;
            end
            sq = longint'(unsigned'(sum)) * longint'(unsigned'(sum));
            sq = (sq + (64'd1 << 43)) >> 44;
            lut[t] = (sq > 64'd65535) ? 16'hFFFF : 16'(sq);
        end
        return lut;
    endfunction

    localparam t_cos_lut COS_LUT = build_cos_lut();

endpackage

FILE: design/vngs_ram.sv
`timescale 1ns / 1ps
// generic single write port ram with registered read
module vngs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/vngs_decode.sv
`timescale 1ns / 1ps
// input decode: bounds check, corner addresses, wrap and blend weights
module vngs_decode
    import vngs_pkg::*;
#(
    parameter int MAX_GRID_WIDTH  = 64,
    parameter int MAX_GRID_HEIGHT = 64,
    parameter int FRACTION_BITS   = 8,
    localparam int AW = $clog2(MAX_GRID_WIDTH * MAX_GRID_HEIGHT)
) (
    input  logic               i_cmd,
    input  logic [COORD_W-1:0] i_x,
    input  logic [COORD_W-1:0] i_y,
    input  logic [CFG_W-1:0]   i_grid_width,
    input  logic [CFG_W-1:0]   i_grid_height,
    input  logic               i_interp_mode,
    output t_ctl               o_ctl,
    output logic [AW-1:0]      o_rd_addr [4],
    output logic [AW-1:0]      o_wr_addr,
    output logic [VALUE_W-1:0] o_wx,
    output logic [VALUE_W-1:0] o_wy
);

    localparam int CXW = $clog2(MAX_GRID_WIDTH);
    localparam int RYW = $clog2(MAX_GRID_HEIGHT);

    logic                     x_neg, y_neg;
    logic [15:0]              ix, iy, ix1, iy1, w_eff, h_eff;
    logic                     in_b, wr_ok;
    logic [CXW-1:0]           col0, col1;
    logic [RYW-1:0]           row0, row1;
    logic [FRACTION_BITS-1:0] fx, fy;
    logic [7:0]               tx, ty;
    logic [VALUE_W-1:0]       lin_x, lin_y;

    function automatic logic [AW-1:0] cell_addr(input logic [RYW-1:0] row,
                                                input logic [CXW-1:0] col);
        return AW'(32'(row) * MAX_GRID_WIDTH + 32'(col));
    endfunction

    always_comb begin
        x_neg = i_x[COORD_W-1];
        y_neg = i_y[COORD_W-1];
        ix    = 16'(i_x >> FRACTION_BITS);
        iy    = 16'(i_y >> FRACTION_BITS);
        w_eff = (16'(i_grid_width) > 16'(MAX_GRID_WIDTH)) ? 16'(MAX_GRID_WIDTH)
                                                          : 16'(i_grid_width);
        h_eff = (16'(i_grid_height) > 16'(MAX_GRID_HEIGHT)) ? 16'(MAX_GRID_HEIGHT)
                                                            : 16'(i_grid_height);
        in_b  = !x_neg && !y_neg && (ix < w_eff) && (iy < h_eff);
        wr_ok = !x_neg && !y_neg && (ix < 16'(MAX_GRID_WIDTH))
                && (iy < 16'(MAX_GRID_HEIGHT));
        ix1   = (ix + 16'd1 == w_eff) ? 16'd0 : ix + 16'd1;
        iy1   = (iy + 16'd1 == h_eff) ? 16'd0 : iy + 16'd1;
        col0  = CXW'(ix);
        col1  = CXW'(ix1);
        row0  = RYW'(iy);
        row1  = RYW'(iy1);

        o_ctl.cmd_wr = (i_cmd == CMD_WRITE);
        o_ctl.wr_ok  = wr_ok;
        o_ctl.oob    = !in_b;

        o_rd_addr[0] = in_b ? cell_addr(row0, col0) : '0;
        o_rd_addr[1] = in_b ? cell_addr(row0, col1) : '0;
        o_rd_addr[2] = in_b ? cell_addr(row1, col0) : '0;
        o_rd_addr[3] = in_b ? cell_addr(row1, col1) : '0;
        o_wr_addr    = wr_ok ? cell_addr(row0, col0) : '0;

        fx    = FRACTION_BITS'(i_x);
        fy    = FRACTION_BITS'(i_y);
        lin_x = 16'(32'(fx) << (16 - FRACTION_BITS));
        lin_y = 16'(32'(fy) << (16 - FRACTION_BITS));
        o_wx  = i_interp_mode ? COS_LUT[tx] : lin_x;
        o_wy  = i_interp_mode ? COS_LUT[ty] : lin_y;
    end

    generate
        if (FRACTION_BITS >= 8) begin : g_idx_hi
            assign tx = fx[FRACTION_BITS-1 -: 8];
            assign ty = fy[FRACTION_BITS-1 -: 8];
        end else begin : g_idx_lo
            assign tx = {fx, {(8 - FRACTION_BITS){1'b0}}};
            assign ty = {fy, {(8 - FRACTION_BITS){1'b0}}};
        end
    endgenerate

endmodule

FILE: design/vngs_lerp.sv
`timescale 1ns / 1ps
// two stage weighted blend of a pair of values in q0.16
module vngs_lerp
    import vngs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en_mul,
    input  logic               i_en_sum,
    input  logic [VALUE_W-1:0] i_a,
    input  logic [VALUE_W-1:0] i_b,
    input  logic [VALUE_W-1:0] i_w,
    output logic [VALUE_W-1:0] o_y
);

    logic [16:0]         wc;
    logic [PROD_W-1:0]   n_pa, n_pb, sum;
    logic [PROD_W-1:0]   r_pa, r_pb;
    logic [VALUE_W-1:0]  r_y;

    always_comb begin
        wc   = W_ONE - 17'(i_w);
        n_pa = PROD_W'(i_a) * PROD_W'(wc);
        n_pb = PROD_W'(i_b) * PROD_W'(i_w);
        sum  = r_pa + r_pb + PROD_W'(32768);
    end

    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            r_pa <= n_pa;
            r_pb <= n_pb;
        end
        if (i_en_sum) begin
            r_y <= VALUE_W'(sum >> 16);
        end
    end

    assign o_y = r_y;

endmodule

FILE: design/value_noise_grid_sampler.sv
`timescale 1ns / 1ps
// top level of the value noise grid sampler
// Takes one item per clock unless a stalled output has backed up to the input; a
// sample passes decode, corner read and two register stages per blend pass, x then y.
// Write items update the grid and produce no output. The grid is held in four
// copies of the cell memory, one per interpolation corner, so all four corners
// are read in the same cycle; every write goes to all four copies. A stalled output
// only holds back as many stages as are full, so bubbles fill up before the
// input stalls. Cells must be written before they are sampled.
module value_noise_grid_sampler
    import vngs_pkg::*;
#(
    parameter int MAX_GRID_WIDTH  = 64,
    parameter int MAX_GRID_HEIGHT = 64,
    parameter int FRACTION_BITS   = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // x_coord, y_coord, cell_value, zero pad
    input  logic                 s_axis_tuser,  // command
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [VALUE_W-1:0]   m_axis_tdata,  // noise_value
    output logic                 m_axis_tuser,  // out_of_bounds
    input  logic                 i_cfg_we,
    input  logic [CFG_AW-1:0]    i_cfg_addr,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int DEPTH = MAX_GRID_WIDTH * MAX_GRID_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    logic [CFG_W-1:0] r_grid_width, r_grid_height;
    logic             r_interp_mode;

    t_ctl               dec_ctl;
    logic [AW-1:0]      dec_rd_addr [4];
    logic [AW-1:0]      dec_wr_addr;
    logic [VALUE_W-1:0] dec_wx, dec_wy;

    logic               r_a_valid, r_b_valid, r_c_valid, r_d_valid, r_e_valid, r_f_valid;
    t_ctl               r_a_ctl;
    logic [AW-1:0]      r_a_rd_addr [4];
    logic [AW-1:0]      r_a_wr_addr;
    logic [VALUE_W-1:0] r_a_wdata, r_a_wx, r_a_wy;
    logic               r_b_oob, r_c_oob, r_d_oob, r_e_oob, r_f_oob;
    logic [VALUE_W-1:0] r_b_wx, r_b_wy, r_c_wy, r_d_wy;

    logic               en_a, en_b, en_c, en_d, en_e, en_f;
    logic               ram_we;
    logic [VALUE_W-1:0] corner [4];
    logic [VALUE_W-1:0] top, bot, y_a, y_b, noise;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= CFG_W'(64);
            r_grid_height <= CFG_W'(64);
            r_interp_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_data;
                CFG_GRID_HEIGHT: r_grid_height <= i_cfg_data;
                CFG_INTERP_MODE: r_interp_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // stall chain, a stage moves when it is empty or the next one moves
    always_comb begin
        en_f = !r_f_valid || m_axis_tready;
        en_e = !r_e_valid || en_f;
        en_d = !r_d_valid || en_e;
        en_c = !r_c_valid || en_d;
        en_b = !r_b_valid || en_c;
        en_a = !r_a_valid || en_b;
    end

    assign s_axis_tready = en_a;

    vngs_decode #(
        .MAX_GRID_WIDTH (MAX_GRID_WIDTH),
        .MAX_GRID_HEIGHT(MAX_GRID_HEIGHT),
        .FRACTION_BITS  (FRACTION_BITS)
    ) u_decode (
        .i_cmd        (s_axis_tuser),
        .i_x          (s_axis_tdata[COORD_W-1:0]),
        .i_y          (s_axis_tdata[2*COORD_W-1:COORD_W]),
        .i_grid_width (r_grid_width),
        .i_grid_height(r_grid_height),
        .i_interp_mode(r_interp_mode),
        .o_ctl        (dec_ctl),
        .o_rd_addr    (dec_rd_addr),
        .o_wr_addr    (dec_wr_addr),
        .o_wx         (dec_wx),
        .o_wy         (dec_wy)
    );

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
        end else begin
            if (en_a) begin
                r_a_valid <= s_axis_tvalid;
            end
            if (en_b) begin
                r_b_valid <= r_a_valid && !r_a_ctl.cmd_wr;
            end
            if (en_c) begin
                r_c_valid <= r_b_valid;
            end
            if (en_d) begin
                r_d_valid <= r_c_valid;
            end
            if (en_e) begin
                r_e_valid <= r_d_valid;
            end
            if (en_f) begin
                r_f_valid <= r_e_valid;
            end
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_ctl     <= dec_ctl;
            r_a_rd_addr <= dec_rd_addr;
            r_a_wr_addr <= dec_wr_addr;
            r_a_wdata   <= s_axis_tdata[2*COORD_W +: VALUE_W];
            r_a_wx      <= dec_wx;
            r_a_wy      <= dec_wy;
        end
        if (en_b) begin
            r_b_oob <= r_a_ctl.oob;
            r_b_wx  <= r_a_wx;
            r_b_wy  <= r_a_wy;
        end
        if (en_c) begin
            r_c_oob <= r_b_oob;
            r_c_wy  <= r_b_wy;
        end
        if (en_d) begin
            r_d_oob <= r_c_oob;
            r_d_wy  <= r_c_wy;
        end
        if (en_e) begin
            r_e_oob <= r_d_oob;
        end
        if (en_f) begin
            r_f_oob <= r_e_oob;
        end
    end

    // a write lands when its item leaves the address stage
    assign ram_we = r_a_valid && r_a_ctl.cmd_wr && r_a_ctl.wr_ok && en_b;

    generate
        for (genvar c = 0; c < 4; c++) begin : g_corner
            vngs_ram #(
                .WIDTH(VALUE_W),
                .DEPTH(DEPTH)
            ) u_ram (
                .i_clk  (i_clk),
                .i_we   (ram_we),
                .i_waddr(r_a_wr_addr),
                .i_wdata(r_a_wdata),
                .i_re   (en_b),
                .i_raddr(r_a_rd_addr[c]),
                .o_rdata(corner[c])
            );
        end
    endgenerate

    vngs_lerp u_lerp_top (
        .i_clk   (i_clk),
        .i_en_mul(en_c),
        .i_en_sum(en_d),
        .i_a     (corner[0]),
        .i_b     (corner[1]),
        .i_w     (r_b_wx),
        .o_y     (top)
    );

    vngs_lerp u_lerp_bot (
        .i_clk   (i_clk),
        .i_en_mul(en_c),
        .i_en_sum(en_d),
        .i_a     (corner[2]),
        .i_b     (corner[3]),
        .i_w     (r_b_wx),
        .o_y     (bot)
    );

    // out of bounds samples blend two zeros
    assign y_a = r_d_oob ? '0 : top;
    assign y_b = r_d_oob ? '0 : bot;

    vngs_lerp u_lerp_y (
        .i_clk   (i_clk),
        .i_en_mul(en_e),
        .i_en_sum(en_f),
        .i_a     (y_a),
        .i_b     (y_b),
        .i_w     (r_d_wy),
        .o_y     (noise)
    );

    assign m_axis_tvalid = r_f_valid;
    assign m_axis_tdata  = noise;
    assign m_axis_tuser  = r_f_oob;

endmodule

FILE: design/vngs_checker.sv
`timescale 1ns / 1ps
// port level checker of the value noise grid sampler and its bind
module vngs_checker
    import vngs_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [VALUE_W-1:0] m_axis_tdata,
    input logic               m_axis_tuser
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_oob_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("out of bounds item with nonzero noise");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output is empty");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output item changed");

endmodule

bind value_noise_grid_sampler vngs_checker u_vngs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);

FILE: bench/value_noise_grid_sampler_tb.sv
`timescale 1ns / 1ps
// self-checking bench for the value noise grid sampler: directed and random sample/write items vs a predictor
module value_noise_grid_sampler_tb;
    import vngs_pkg::*;

    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam int GRID_COLS      = 64;
    localparam int FRAC_BITS      = 8;
    localparam int PHASE_ITEMS    = 110;
    localparam int HOLD_CYCLES    = 400;
    localparam int RUSH_ITEMS     = 60;
    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam int unsigned PLAN_W [7] = '{64, 1, 1, 64, 0, 127, 100};
    localparam int unsigned PLAN_H [7] = '{64, 1, 64, 1, 100, 0, 127};
    localparam int unsigned PLAN_M [7] = '{1, 0, 1, 0, 1, 0, 1};

    typedef struct {
        logic [VALUE_W-1:0] noise;
        logic               oob;
    } t_noise_result;

    class noise_grid_predictor;
        logic [VALUE_W-1:0] grid [4096];
        bit                 written [4096];
        logic [16:0]        weight [256];
        int                 cols_used;
        int                 rows_used;
        bit                 cosine_mode;
        t_noise_result      pending [$];
        int                 mismatches;

        function new();
            longint unsigned ang;
            longint unsigned term;
            longint unsigned sq;
            longint          acc;
            for (int t = 0; t < 256; t++) begin
                ang  = (PI_Q30 * 64'(t) + 64'd256) >> 9;
                term = ang;
                acc  = longint'(ang);
                for (int k = 1; k <= 7; k++) begin
                    term = (term * ang) >> 30;
                    term = (term * ang) >> 30;
                    term = term / 64'(2 * k * (2 * k + 1));
                    if (k % 2 == 1) begin
                        acc = acc - longint'(term);
                    end else begin
                        acc = acc + longint'(term);
                    end
                end
                if (acc < 0) begin
                    acc = 0;
                end
                if (acc > (longint'(1) << 30)) begin
                    acc = longint'(1) << 30;
                end
                sq = longint'(acc) * longint'(acc);
                sq = (sq + (64'd1 << 43)) >> 44;
                weight[t] = (sq > 64'd65535) ? 17'd65535 : 17'(sq);
            end
            cols_used   = 64;
            rows_used   = 64;
            cosine_mode = 1'b0;
            mismatches  = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, int unsigned val);
            case (idx)
                CFG_GRID_WIDTH: begin
                    cols_used = ((val & 127) > 64) ? 64 : int'(val & 127);
                end
                CFG_GRID_HEIGHT: begin
                    rows_used = ((val & 127) > 64) ? 64 : int'(val & 127);
                end
                CFG_INTERP_MODE: begin
                    cosine_mode = val[0];
                end
                default: begin
                end
            endcase
        endfunction

        // four corner cells of a sample, top pair first; 0 when outside the grid
        function bit corner_addrs(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                  output int addr [4]);
            int ix;
            int iy;
            int nx;
            int ny;
            if (x[14] || y[14] || int'(x[13:8]) >= cols_used || int'(y[13:8]) >= rows_used) begin
                return 1'b0;
            end
            ix   = x[13:8];
            iy   = y[13:8];
            nx   = (ix + 1 == cols_used) ? 0 : ix + 1;
            ny   = (iy + 1 == rows_used) ? 0 : iy + 1;
            addr = '{iy * GRID_COLS + ix, iy * GRID_COLS + nx,
                     ny * GRID_COLS + ix, ny * GRID_COLS + nx};
            return 1'b1;
        endfunction

        function logic [VALUE_W-1:0] blend(logic [VALUE_W-1:0] lo, logic [VALUE_W-1:0] hi,
                                           logic [FRAC_BITS-1:0] f);
            longint unsigned a;
            longint unsigned b;
            longint unsigned w;
            a = lo;
            b = hi;
            if (cosine_mode) begin
                w = weight[f];
                return 16'((a * (64'd65536 - w) + b * w + 64'd32768) >> 16);
            end
            w = f;
            return 16'((a * (64'd256 - w) + b * w + 64'd128) >> FRAC_BITS);
        endfunction

        function void take_item(logic cmd, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                logic [VALUE_W-1:0] val);
            int                 corner [4];
            logic [VALUE_W-1:0] upper;
            logic [VALUE_W-1:0] lower;
            t_noise_result      res;
            if (cmd == CMD_WRITE) begin
                if (!x[14] && !y[14]) begin
                    grid[{y[13:8], x[13:8]}]    = val;
                    written[{y[13:8], x[13:8]}] = 1'b1;
                end
                return;
            end
            if (corner_addrs(x, y, corner)) begin
                upper     = blend(grid[corner[0]], grid[corner[1]], x[7:0]);
                lower     = blend(grid[corner[2]], grid[corner[3]], x[7:0]);
                res.noise = blend(upper, lower, y[7:0]);
                res.oob   = 1'b0;
            end else begin
                res.noise = '0;
                res.oob   = 1'b1;
            end
            pending.insert(pending.size(), res);
        endfunction

        function void check_noise(logic [VALUE_W-1:0] noise, logic oob);
            t_noise_result want;
            if (pending.size() == 0) begin
                $error("unexpected item: noise_value %h out_of_bounds %b", noise, oob);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            if (noise !== want.noise) begin
                $error("noise_value: expected %h, actual %h", want.noise, noise);
                mismatches++;
            end
            if (oob !== want.oob) begin
                $error("out_of_bounds: expected %b, actual %b", want.oob, oob);
                mismatches++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;  // x_coord, y_coord, cell_value, zero pad
    logic                 s_axis_tuser;  // command
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [VALUE_W-1:0]   m_axis_tdata;  // noise_value
    logic                 m_axis_tuser;  // out_of_bounds
    logic                 i_cfg_we;
    logic [CFG_AW-1:0]    i_cfg_addr;
    logic [CFG_W-1:0]     i_cfg_data;

    noise_grid_predictor pred;
    int                  items_sent  = 0;
    int                  rush_left   = 0;
    int                  quiet_cycles = 0;
    bit                  tx_burst    = 1'b0;
    bit                  rx_burst    = 1'b0;
    bit                  rx_hold_req = 1'b0;

    value_noise_grid_sampler u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    task automatic send_item(logic cmd, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                             logic [VALUE_W-1:0] val);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {2'b00, val, y, x};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        pred.take_item(cmd, x, y, val);
        if (!(cmd == CMD_WRITE && (x[14] || y[14]))) begin
            items_sent++;
        end
        if (rush_left > 0) begin
            rush_left--;
            gap = 0;
        end else begin
            gap = tx_burst ? 0 : $urandom_range(0, 17);
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // fills any unwritten corner first so no sample reads an undefined cell
    task automatic sample_at(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        int addr [4];
        if (pred.corner_addrs(x, y, addr)) begin
            foreach (addr[i]) begin
                if (!pred.written[addr[i]]) begin
                    send_item(CMD_WRITE,
                              15'(((addr[i] % GRID_COLS) << 8) | $urandom_range(0, 255)),
                              15'(((addr[i] / GRID_COLS) << 8) | $urandom_range(0, 255)),
                              16'($urandom));
                end
            end
        end
        send_item(CMD_SAMPLE, x, y, 16'($urandom));
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pred.pending.size() > 0);
    endtask

    task automatic write_regs(int unsigned gw, int unsigned gh, int unsigned mode);
        t_cfg_idx    regs [3];
        int unsigned vals [3];
        regs = '{CFG_GRID_WIDTH, CFG_GRID_HEIGHT, CFG_INTERP_MODE};
        vals = '{gw, gh, mode};
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        for (int i = 0; i < 3; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_addr <= regs[i];
            i_cfg_data <= CFG_W'(vals[i]);
            @(posedge i_clk);
            pred.set_reg(regs[i], vals[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_items(int n, bit long_hold, bit mid_pause);
        int                 start;
        int                 pick;
        bit                 held;
        bit                 paused;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        start  = items_sent;
        held   = 1'b0;
        paused = 1'b0;
        while (items_sent < start + n) begin
            if ($urandom_range(0, 31) == 0) begin
                tx_burst = ($urandom_range(0, 2) == 0);
            end
            if (long_hold && !held && items_sent >= start + 20) begin
                held        = 1'b1;
                rx_hold_req = 1'b1;
                rush_left   = RUSH_ITEMS;
            end
            if (mid_pause && !paused && items_sent >= start + 50) begin
                paused = 1'b1;
                wait_results_drained();
            end
            pick = $urandom_range(0, 99);
            if (pick < 55 && pred.cols_used > 0 && pred.rows_used > 0) begin
                x = 15'($urandom_range(0, pred.cols_used * 256 - 1));
                y = 15'($urandom_range(0, pred.rows_used * 256 - 1));
                if ($urandom_range(0, 7) == 0) begin
                    x[7:0] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                end
                if ($urandom_range(0, 7) == 0) begin
                    y[7:0] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                end
                sample_at(x, y);
            end else if (pick < 70) begin
                sample_at(15'($urandom), 15'($urandom));
            end else if (pick < 93) begin
                send_item(CMD_WRITE, 15'($urandom_range(0, 16383)),
                          15'($urandom_range(0, 16383)), 16'($urandom));
            end else begin
                send_item(CMD_WRITE, 15'($urandom), 15'($urandom), 16'($urandom));
            end
        end
    endtask

    // result side
    initial begin
        int stall;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if ($urandom_range(0, 31) == 0) begin
                rx_burst = ($urandom_range(0, 2) == 0);
            end
            stall = rx_burst ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            pred.check_noise(m_axis_tdata, m_axis_tuser);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1)
                || (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) || i_rst_n !== 1'b1) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        pred = new();
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_SAMPLE;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= CFG_GRID_WIDTH;
        i_cfg_data    <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corners of the grid, full-scale values, ignored writes
        send_item(CMD_WRITE, 15'h0000, 15'h0000, 16'h0000);
        send_item(CMD_WRITE, 15'h0100, 15'h0000, 16'hFFFF);
        send_item(CMD_WRITE, 15'h0000, 15'h0100, 16'hFFFF);
        send_item(CMD_WRITE, 15'h0100, 15'h0100, 16'h0000);
        send_item(CMD_WRITE, 15'h3FFF, 15'h0000, 16'hFFFF);
        send_item(CMD_WRITE, 15'h0000, 15'h3F00, 16'h8000);
        send_item(CMD_WRITE, 15'h3FFF, 15'h3FFF, 16'h0001);
        send_item(CMD_WRITE, 15'h7FFF, 15'h7FFF, 16'h5555);
        send_item(CMD_WRITE, 15'h4000, 15'h0000, 16'hAAAA);
        sample_at(15'h0000, 15'h0000);
        sample_at(15'h00FF, 15'h00FF);
        sample_at(15'h0080, 15'h0080);
        sample_at(15'h0001, 15'h0000);
        sample_at(15'h3FFF, 15'h3FFF);
        sample_at(15'h3FFF, 15'h0000);
        sample_at(15'h7FFF, 15'h0000);
        sample_at(15'h0000, 15'h4000);
        sample_at(15'h4000, 15'h4000);
        write_regs(64, 64, 1);
        sample_at(15'h0080, 15'h0080);
        sample_at(15'h00FF, 15'h00FF);
        sample_at(15'h0040, 15'h00C0);

        for (int p = 0; p < 12; p++) begin
            if (p < 7) begin
                write_regs(PLAN_W[p], PLAN_H[p], PLAN_M[p]);
            end else begin
                write_regs($urandom_range(2, 64), $urandom_range(2, 64), $urandom_range(0, 1));
            end
            random_items(PHASE_ITEMS, p == 7, p == 8);
        end

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pred.mismatches == 0 && pred.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
